FILE: design/ssum_pkg.sv
// ----------------------------------------------------------------------------
// ssum_pkg
// Shared types and constants for the subset-sum search block.
// ----------------------------------------------------------------------------
package ssum_pkg;

  localparam int unsigned MAX_ELEMENTS_DEF = 16;
  localparam int unsigned VALUE_BITS_DEF   = 16;
  localparam int unsigned ITEM_W           = 16;
  localparam int unsigned TARGET_W         = 32;

  typedef struct packed {
    logic signed [ITEM_W-1:0] item_value;
    logic                     is_last;
  } ssum_item_t;

  typedef struct packed {
    logic found;
    logic overflowed;
  } ssum_result_t;

  // sequencer to accumulator
  typedef struct packed {
    logic clr;  // zero sum and subset mask
    logic upd;  // toggle one element into/out of the subset
  } ssum_acc_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ADD
  } ssum_state_e;

endpackage

FILE: design/ssum_store.sv
// ----------------------------------------------------------------------------
// ssum_store
// Element memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ssum_store import ssum_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int unsigned VALUE_BITS   = VALUE_BITS_DEF,
  localparam int unsigned IDX_W       = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [IDX_W-1:0]      waddr_i,
  input  logic [VALUE_BITS-1:0] wdata_i,
  input  logic [IDX_W-1:0]      raddr_i,
  output logic [VALUE_BITS-1:0] rdata_o
);

  logic [VALUE_BITS-1:0] mem_q [MAX_ELEMENTS];
  logic [VALUE_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/ssum_acc.sv
// ----------------------------------------------------------------------------
// ssum_acc
// Shared add/subtract unit with running sum, subset mask and target compare.
// ----------------------------------------------------------------------------
module ssum_acc import ssum_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int unsigned VALUE_BITS   = VALUE_BITS_DEF,
  localparam int unsigned IDX_W       = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ssum_acc_ctrl_t             ctrl_i,
  input  logic [IDX_W-1:0]           idx_i,
  input  logic [VALUE_BITS-1:0]      elem_i,
  input  logic signed [TARGET_W-1:0] target_i,
  output logic                       hit_o
);

  // wide enough for the sum of every element at its extreme
  localparam int unsigned SUM_W = VALUE_BITS + $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned CMP_W = (SUM_W > TARGET_W) ? SUM_W : TARGET_W;

  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic [MAX_ELEMENTS-1:0]  mask_q, mask_d;
  logic signed [SUM_W-1:0]  elem_ext;
  logic signed [CMP_W-1:0]  sum_cmp, tgt_cmp;

  assign elem_ext = SUM_W'($signed(elem_i));

  always_comb begin
    sum_d  = sum_q;
    mask_d = mask_q;
    priority if (ctrl_i.clr) begin
      sum_d  = '0;
      mask_d = '0;
    end else if (ctrl_i.upd) begin
      // element leaves the subset if present, joins otherwise
      sum_d          = mask_q[idx_i] ? (sum_q - elem_ext) : (sum_q + elem_ext);
      mask_d[idx_i]  = ~mask_q[idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      mask_q <= '0;
    end else begin
      sum_q  <= sum_d;
      mask_q <= mask_d;
    end
  end

  assign sum_cmp = CMP_W'(sum_q);
  assign tgt_cmp = CMP_W'(target_i);
  assign hit_o   = (sum_cmp == tgt_cmp);

endmodule

FILE: design/ssum_ctrl.sv
// ----------------------------------------------------------------------------
// ssum_ctrl
// Load sequencer and Gray-code step counter for the subset walk.
// ----------------------------------------------------------------------------
module ssum_ctrl import ssum_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int unsigned VALUE_BITS   = VALUE_BITS_DEF,
  localparam int unsigned IDX_W       = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  ssum_item_t            item_i,
  output logic                  busy_o,
  output logic                  done_o,
  output ssum_result_t          result_o,
  // element store
  output logic                  we_o,
  output logic [IDX_W-1:0]      waddr_o,
  output logic [VALUE_BITS-1:0] wdata_o,
  output logic [IDX_W-1:0]      raddr_o,
  // accumulator
  output ssum_acc_ctrl_t        acc_o,
  input  logic                  hit_i
);

  localparam int unsigned CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned STEP_W = MAX_ELEMENTS + 1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_ELEMENTS);
  localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1);

  ssum_state_e         state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                ovf_q, ovf_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                done_q, done_d;
  ssum_result_t        res_q, res_d;

  logic                accept;
  logic                full;
  logic [STEP_W-1:0]   total;
  logic [IDX_W-1:0]    flip_idx;

  assign accept = start_i && (state_q == ST_IDLE);
  assign full   = (count_q == CNT_MAX);
  assign total  = STEP_ONE << count_q;

  // lowest set bit of the step count picks the element to flip
  always_comb begin
    flip_idx = '0;
    for (int i = MAX_ELEMENTS - 1; i >= 0; i--) begin
      if (step_q[i]) begin
        flip_idx = IDX_W'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && item_i.is_last) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (hit_i || (step_q == total)) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_ADD;
        end
      end
      ST_ADD:  state_d = ST_CHECK;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control and outputs
  always_comb begin
    count_d   = count_q;
    ovf_d     = ovf_q;
    step_d    = step_q;
    done_d    = 1'b0;
    res_d     = res_q;
    we_o      = 1'b0;
    acc_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            we_o    = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
          if (item_i.is_last) begin
            acc_o.clr = 1'b1;
            step_d    = STEP_ONE;
          end
        end
      end
      ST_CHECK: begin
        if (hit_i || (step_q == total)) begin
          done_d           = 1'b1;
          res_d.found      = hit_i;
          res_d.overflowed = ovf_q;
          count_d          = '0;
          ovf_d            = 1'b0;
        end
      end
      ST_ADD: begin
        acc_o.upd = 1'b1;
        step_d    = step_q + STEP_ONE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;
  assign waddr_o  = count_q[IDX_W-1:0];
  assign wdata_o  = VALUE_BITS'($unsigned(item_i.item_value));
  assign raddr_o  = flip_idx;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held longer than one cycle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result strobe while search still running");

  a_add_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD) |=> (state_q == ST_CHECK))
    else $error("accumulate step not followed by compare");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (step_q <= total))
    else $error("subset walk ran past the last subset");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_MAX)
    else $error("element count beyond store depth");

endmodule

FILE: design/subset_sum_search.sv
// ----------------------------------------------------------------------------
// subset_sum_search
// Loads a set of signed elements, then walks all subsets in Gray-code order
// with a running sum and reports whether any subset hits the target.
// ----------------------------------------------------------------------------
// Load: a beat that is not last is written to the element store on acceptance; busy_o stays low.
// A last beat over N stored elements starts a search; done_o is raised after
// the last subset's compare (earlier on a hit): one compare, then an add/compare
// pair per further subset, the element memory read overlapping each compare.
// Throughput: one set per search; done_o is a one-cycle strobe, never stalled.
// Reset: sequencer state, counts, sum and target (0) cleared; store and result_o undefined.
// ----------------------------------------------------------------------------
module subset_sum_search import ssum_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int unsigned VALUE_BITS   = VALUE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // item channel
  input  logic                       start_i,
  input  ssum_item_t                 item_i,
  output logic                       busy_o,
  // result channel
  output logic                       done_o,
  output ssum_result_t               result_o,
  // target register write channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic signed [TARGET_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  logic signed [TARGET_W-1:0] target_q;

  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [VALUE_BITS-1:0] wdata;
  logic [IDX_W-1:0]      raddr;
  logic [VALUE_BITS-1:0] rdata;
  ssum_acc_ctrl_t        acc_ctrl;
  logic                  hit;

  // Target register: always writable, only touched while idle by contract.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      target_q <= cfg_data_i;
    end
  end

  // Sequencer: stores elements on load, then steps the Gray-code walk.
  // Read address is the lowest set bit of the step count, which the
  // accumulator uses in the following cycle to flip that element.
  ssum_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .item_i   (item_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o),
    .we_o     (we),
    .waddr_o  (waddr),
    .wdata_o  (wdata),
    .raddr_o  (raddr),
    .acc_o    (acc_ctrl),
    .hit_i    (hit)
  );

  // Element memory, registered read.
  ssum_store #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Shared adder/subtractor; compare of the running sum against the target
  // happens on the registered sum, so the empty subset is checked first.
  ssum_acc #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (acc_ctrl),
    .idx_i    (raddr),
    .elem_i   (rdata),
    .target_i (target_q),
    .hit_o    (hit)
  );

endmodule
